[hw/rtl/cda_pkg.sv]
// Shared types and constants for the calendar date arithmetic block.
// Holds the command and sequencer codes and the request/response payloads.
// No dependencies.
package cda_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;

   localparam logic [13:0] YEAR_MAX  = 14'd9999;
   localparam logic [13:0] YEAR_MIN  = 14'd1;
   localparam logic [3:0]  MONTH_MAX = 4'd12;
   localparam logic [3:0]  MONTH_MIN = 4'd1;
   localparam logic [4:0]  DAY_MIN   = 5'd1;
   localparam logic [4:0]  DAY_MAX   = 5'd31;

   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_ADD  = 2'd1,
      CMD_SUB  = 2'd2,
      CMD_DIST = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIX,
      ST_ADD,
      ST_SUB,
      ST_BACK,
      ST_DIST,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [13:0] in_year;
      logic [3:0]  in_month;
      logic [4:0]  in_day;
      logic [15:0] day_count;
   } req_payload_type;

   typedef struct packed {
      logic [13:0] out_year;
      logic [3:0]  out_month;
      logic [4:0]  out_day;
      logic [15:0] distance;
      logic        clamped;
   } rsp_payload_type;

endpackage

[hw/rtl/cda_req_if.sv]
// Request channel for the calendar date arithmetic block.
// Depends on cda_pkg for the request payload type.
interface cda_req_if;
   logic                       valid;
   logic                       ready;
   cda_pkg::req_payload_type   payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/cda_rsp_if.sv]
// Response channel for the calendar date arithmetic block.
// Depends on cda_pkg for the response payload type.
interface cda_rsp_if;
   logic                       valid;
   logic                       ready;
   cda_pkg::rsp_payload_type   payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/cda_month_unit.sv]
// Month length unit: Gregorian leap test and length of a given month.
// Shared by every step of the sequencer. Depends on cda_pkg.
module cda_month_unit (
   input  logic [13:0] year,
   input  logic [3:0]  month,
   output logic [4:0]  month_len
);

   logic [11:0] quarter;
   logic [24:0] prod;
   logic [7:0]  cent;
   logic [11:0] cent_x25;
   logic        div4;
   logic        div100;
   logic        leap;

   // year/100 from (year/4)/25 by reciprocal multiply
   assign quarter  = year[13:2];
   assign prod     = 25'(quarter) * 25'd5243;
   assign cent     = prod[24:17];
   assign cent_x25 = {cent, 4'b0000} + {1'b0, cent, 3'b000} + 12'(cent);
   assign div4     = (year[1:0] == 2'b00);
   assign div100   = div4 && (quarter == cent_x25);
   assign leap     = div4 && (!div100 || (cent[1:0] == 2'b00));

   always_comb begin
      case (month)
         4'd2:                       month_len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:    month_len = 5'd30;
         default:                    month_len = cda_pkg::DAY_MAX;
      endcase
   end

endmodule

[hw/rtl/cda_engine.sv]
// Sequencer and date registers: clamps given dates, steps month by month
// for add, subtract and distance. Depends on cda_pkg and cda_month_unit.
module cda_engine #(
   parameter int COUNT_BITS = cda_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  cda_pkg::req_payload_type  req,
   input  logic                      take,
   output logic                      idle,
   output logic                      done,
   output cda_pkg::rsp_payload_type  result
);

   localparam int CNT_W = (COUNT_BITS < 16) ? COUNT_BITS : 16;
   localparam logic [16:0] DIST_MAX = (COUNT_BITS < 16) ?
      17'((64'd1 << COUNT_BITS) - 64'd1) : 17'd65535;

   cda_pkg::state_type state_ff, state_in;
   cda_pkg::cmd_type   cmd_ff, cmd_in;

   logic [13:0]      held_year_ff, held_year_in;
   logic [3:0]       held_month_ff, held_month_in;
   logic [4:0]       held_day_ff, held_day_in;
   logic [13:0]      wy_ff, wy_in;
   logic [3:0]       wm_ff, wm_in;
   logic [4:0]       wd_ff, wd_in;
   logic [13:0]      ty_ff, ty_in;
   logic [3:0]       tm_ff, tm_in;
   logic [4:0]       td_ff, td_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [16:0]      acc_ff, acc_in;
   logic             clamp_ff, clamp_in;

   logic [4:0]  ml;
   logic [4:0]  fd;
   logic        fix_clip;
   logic [4:0]  left;
   logic        add_fits;
   logic        sub_fits;
   logic        at_top;
   logic        at_bottom;
   logic        same_month;
   logic [4:0]  step_days;
   logic [16:0] acc_sum;
   logic        over;
   logic        given_lower;
   logic [13:0] next_y, prev_y;
   logic [3:0]  next_m, prev_m;
   cda_pkg::cmd_type req_cmd;

   cda_month_unit u_month (
      .year      (wy_ff),
      .month     (wm_ff),
      .month_len (ml)
   );

   assign req_cmd    = cda_pkg::cmd_type'(req.command);
   assign fix_clip   = (wd_ff == 5'd0) || (wd_ff > ml);
   assign fd         = (wd_ff == 5'd0) ? cda_pkg::DAY_MIN : ((wd_ff > ml) ? ml : wd_ff);
   assign left       = ml - wd_ff;
   assign add_fits   = (cnt_ff <= CNT_W'(left));
   assign sub_fits   = (cnt_ff < CNT_W'(wd_ff));
   assign at_top     = (wy_ff == cda_pkg::YEAR_MAX) && (wm_ff == cda_pkg::MONTH_MAX);
   assign at_bottom  = (wy_ff == cda_pkg::YEAR_MIN) && (wm_ff == cda_pkg::MONTH_MIN);
   assign same_month = (wy_ff == ty_ff) && (wm_ff == tm_ff);
   assign step_days  = same_month ? (td_ff - wd_ff) : (left + 5'd1);
   assign acc_sum    = acc_ff + 17'(step_days);
   assign over       = (acc_sum > DIST_MAX);
   assign given_lower = {wy_ff, wm_ff, fd} < {held_year_ff, held_month_ff, held_day_ff};

   assign next_m = (wm_ff == cda_pkg::MONTH_MAX) ? cda_pkg::MONTH_MIN : wm_ff + 4'd1;
   assign next_y = (wm_ff == cda_pkg::MONTH_MAX) ? wy_ff + 14'd1 : wy_ff;
   assign prev_m = (wm_ff == cda_pkg::MONTH_MIN) ? cda_pkg::MONTH_MAX : wm_ff - 4'd1;
   assign prev_y = (wm_ff == cda_pkg::MONTH_MIN) ? wy_ff - 14'd1 : wy_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cda_pkg::ST_IDLE: begin
            if (start) begin
               case (req_cmd)
                  cda_pkg::CMD_ADD: state_in = cda_pkg::ST_ADD;
                  cda_pkg::CMD_SUB: state_in = cda_pkg::ST_SUB;
                  default:          state_in = cda_pkg::ST_FIX;
               endcase
            end
         end
         cda_pkg::ST_FIX: begin
            state_in = (cmd_ff == cda_pkg::CMD_LOAD) ? cda_pkg::ST_DONE : cda_pkg::ST_DIST;
         end
         cda_pkg::ST_ADD: begin
            if (add_fits || at_top) state_in = cda_pkg::ST_DONE;
         end
         cda_pkg::ST_SUB: begin
            if (sub_fits || at_bottom) state_in = cda_pkg::ST_DONE;
            else                       state_in = cda_pkg::ST_BACK;
         end
         cda_pkg::ST_BACK: state_in = cda_pkg::ST_SUB;
         cda_pkg::ST_DIST: begin
            if (same_month || over) state_in = cda_pkg::ST_DONE;
         end
         cda_pkg::ST_DONE: begin
            if (take) state_in = cda_pkg::ST_IDLE;
         end
         default: state_in = cda_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      cmd_in        = cmd_ff;
      held_year_in  = held_year_ff;
      held_month_in = held_month_ff;
      held_day_in   = held_day_ff;
      wy_in         = wy_ff;
      wm_in         = wm_ff;
      wd_in         = wd_ff;
      ty_in         = ty_ff;
      tm_in         = tm_ff;
      td_in         = td_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      clamp_in      = clamp_ff;
      unique case (state_ff)
         cda_pkg::ST_IDLE: begin
            if (start) begin
               cmd_in   = req_cmd;
               cnt_in   = req.day_count[CNT_W-1:0];
               acc_in   = 17'd0;
               clamp_in = 1'b0;
               if ((req_cmd == cda_pkg::CMD_ADD) || (req_cmd == cda_pkg::CMD_SUB)) begin
                  wy_in = held_year_ff;
                  wm_in = held_month_ff;
                  wd_in = held_day_ff;
               end else begin
                  wy_in = req.in_year;
                  wm_in = req.in_month;
                  wd_in = req.in_day;
                  if (req.in_year < cda_pkg::YEAR_MIN) begin
                     wy_in    = cda_pkg::YEAR_MIN;
                     clamp_in = 1'b1;
                  end
                  if (req.in_year > cda_pkg::YEAR_MAX) begin
                     wy_in    = cda_pkg::YEAR_MAX;
                     clamp_in = 1'b1;
                  end
                  if (req.in_month < cda_pkg::MONTH_MIN) begin
                     wm_in    = cda_pkg::MONTH_MIN;
                     clamp_in = 1'b1;
                  end
                  if (req.in_month > cda_pkg::MONTH_MAX) begin
                     wm_in    = cda_pkg::MONTH_MAX;
                     clamp_in = 1'b1;
                  end
               end
            end
         end
         cda_pkg::ST_FIX: begin
            clamp_in = clamp_ff | fix_clip;
            wd_in    = fd;
            if (cmd_ff == cda_pkg::CMD_LOAD) begin
               held_year_in  = wy_ff;
               held_month_in = wm_ff;
               held_day_in   = fd;
            end else if (given_lower) begin
               ty_in = held_year_ff;
               tm_in = held_month_ff;
               td_in = held_day_ff;
            end else begin
               ty_in = wy_ff;
               tm_in = wm_ff;
               td_in = fd;
               wy_in = held_year_ff;
               wm_in = held_month_ff;
               wd_in = held_day_ff;
            end
         end
         cda_pkg::ST_ADD: begin
            if (add_fits) begin
               held_year_in  = wy_ff;
               held_month_in = wm_ff;
               held_day_in   = wd_ff + cnt_ff[4:0];
            end else if (at_top) begin
               held_year_in  = cda_pkg::YEAR_MAX;
               held_month_in = cda_pkg::MONTH_MAX;
               held_day_in   = cda_pkg::DAY_MAX;
               clamp_in      = 1'b1;
            end else begin
               cnt_in = cnt_ff - (CNT_W'(left) + CNT_W'(1));
               wd_in  = cda_pkg::DAY_MIN;
               wm_in  = next_m;
               wy_in  = next_y;
            end
         end
         cda_pkg::ST_SUB: begin
            if (sub_fits) begin
               held_year_in  = wy_ff;
               held_month_in = wm_ff;
               held_day_in   = wd_ff - cnt_ff[4:0];
            end else if (at_bottom) begin
               held_year_in  = cda_pkg::YEAR_MIN;
               held_month_in = cda_pkg::MONTH_MIN;
               held_day_in   = cda_pkg::DAY_MIN;
               clamp_in      = 1'b1;
            end else begin
               cnt_in = cnt_ff - CNT_W'(wd_ff);
               wm_in  = prev_m;
               wy_in  = prev_y;
            end
         end
         cda_pkg::ST_BACK: begin
            wd_in = ml;
         end
         cda_pkg::ST_DIST: begin
            if (over) begin
               acc_in   = DIST_MAX;
               clamp_in = 1'b1;
            end else begin
               acc_in = acc_sum;
               if (!same_month) begin
                  wd_in = cda_pkg::DAY_MIN;
                  wm_in = next_m;
                  wy_in = next_y;
               end
            end
         end
         cda_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cda_pkg::ST_IDLE;
         held_year_ff  <= cda_pkg::YEAR_MIN;
         held_month_ff <= cda_pkg::MONTH_MIN;
         held_day_ff   <= cda_pkg::DAY_MIN;
      end else begin
         state_ff      <= state_in;
         held_year_ff  <= held_year_in;
         held_month_ff <= held_month_in;
         held_day_ff   <= held_day_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      wy_ff    <= wy_in;
      wm_ff    <= wm_in;
      wd_ff    <= wd_in;
      ty_ff    <= ty_in;
      tm_ff    <= tm_in;
      td_ff    <= td_in;
      cnt_ff   <= cnt_in;
      acc_ff   <= acc_in;
      clamp_ff <= clamp_in;
   end

   assign idle             = (state_ff == cda_pkg::ST_IDLE);
   assign done             = (state_ff == cda_pkg::ST_DONE);
   assign result.out_year  = held_year_ff;
   assign result.out_month = held_month_ff;
   assign result.out_day   = held_day_ff;
   assign result.distance  = acc_ff[15:0];
   assign result.clamped   = clamp_ff;

endmodule

[hw/rtl/calendar_date_arithmetic.sv]
// Calendar date arithmetic, top level: request/response handshake and output register.
// Load clamps the given date and stores it as the held date; add and subtract step the
// held date month by month; distance steps month by month from the earlier date to the later one (stops at the limit).
// Throughput: one request at a time; a new request is accepted only when the engine is idle.
// Reset: held date returns to 0001-01-01, no response pending.
// Depends on cda_pkg, cda_req_if, cda_rsp_if and cda_engine.
module calendar_date_arithmetic #(
   parameter int COUNT_BITS = cda_pkg::COUNT_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   cda_req_if.sink      req_chan,
   cda_rsp_if.source    rsp_chan
);

   logic                     eng_idle;
   logic                     eng_done;
   logic                     start;
   logic                     take;
   cda_pkg::rsp_payload_type eng_result;
   cda_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   cda_engine #(
      .COUNT_BITS (COUNT_BITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req    (req_chan.payload),
      .take   (take),
      .idle   (eng_idle),
      .done   (eng_done),
      .result (eng_result)
   );

   assign req_chan.ready = eng_idle;
   assign start          = req_chan.valid && eng_idle;
   assign take           = eng_done && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule
